// ===== rtl/csc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_pkg
// shared widths, constants, arctangent table and pipeline word type
// ----------------------------------------------------------------------------
package csc_pkg;

  localparam int ITERATIONS = 16;
  localparam int DATA_WIDTH = 16;
  localparam int TABLE_LEN  = 16;
  localparam int IDX_W      = $clog2(TABLE_LEN);

  localparam int ANGLE_W = 16;
  localparam int OUT_W   = 16;
  localparam int XY_W    = ((DATA_WIDTH > 16) ? DATA_WIDTH : 16) + 2;
  localparam int Z_W     = ANGLE_W + 1;

  localparam logic signed [ANGLE_W-1:0] HALF_PI_Q14 = 16'sd25735;
  localparam logic signed [XY_W-1:0]    GAIN_Q15    = XY_W'(19898);
  localparam logic signed [XY_W-1:0]    SAT_MAX     = XY_W'((64'd1 << (DATA_WIDTH - 1)) - 1);
  localparam logic signed [XY_W-1:0]    SAT_MIN     = -SAT_MAX - XY_W'(1);

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic                   oor;
  } csc_data_t;

  // atan(2^-i) in q14, rounded
  function automatic logic signed [Z_W-1:0] atan_q14(input logic [IDX_W-1:0] idx);
    logic signed [Z_W-1:0] v;
    unique case (idx)
      4'd0:    v = Z_W'(12868);
      4'd1:    v = Z_W'(7596);
      4'd2:    v = Z_W'(4014);
      4'd3:    v = Z_W'(2037);
      4'd4:    v = Z_W'(1023);
      4'd5:    v = Z_W'(512);
      4'd6:    v = Z_W'(256);
      4'd7:    v = Z_W'(128);
      4'd8:    v = Z_W'(64);
      4'd9:    v = Z_W'(32);
      4'd10:   v = Z_W'(16);
      4'd11:   v = Z_W'(8);
      4'd12:   v = Z_W'(4);
      4'd13:   v = Z_W'(2);
      4'd14:   v = Z_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/csc_pre.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_pre
// input register: range check and cordic start vector
// ----------------------------------------------------------------------------
module csc_pre (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [csc_pkg::ANGLE_W-1:0]  angle,
  output logic                                out_valid,
  input  logic                                out_ready,
  output csc_pkg::csc_data_t                  out_data
);

  csc_pkg::csc_data_t data_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    data_next.x   = csc_pkg::GAIN_Q15;
    data_next.y   = '0;
    data_next.z   = csc_pkg::Z_W'(angle);
    data_next.oor = (angle > csc_pkg::HALF_PI_Q14) || (angle < -csc_pkg::HALF_PI_Q14);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= data_next;
    end
  end

endmodule

// ===== rtl/csc_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_stage
// one registered rotation-mode cordic iteration
// ----------------------------------------------------------------------------
module csc_stage (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [csc_pkg::IDX_W-1:0]         shift,
  input  logic signed [csc_pkg::Z_W-1:0]    atan,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  csc_pkg::csc_data_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output csc_pkg::csc_data_t                out_data
);

  logic signed [csc_pkg::XY_W-1:0] xs;
  logic signed [csc_pkg::XY_W-1:0] ys;
  csc_pkg::csc_data_t              data_next;

  assign in_ready = !out_valid || out_ready;
  assign xs       = in_data.x >>> shift;
  assign ys       = in_data.y >>> shift;

  always_comb begin
    data_next.oor = in_data.oor;
    if (in_data.z > 0) begin
      data_next.x = in_data.x - ys;
      data_next.y = in_data.y + xs;
      data_next.z = in_data.z - atan;
    end else begin
      data_next.x = in_data.x + ys;
      data_next.y = in_data.y - xs;
      data_next.z = in_data.z + atan;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= data_next;
    end
  end

endmodule

// ===== rtl/csc_post.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_post
// output register: saturation and out-of-range forcing
// ----------------------------------------------------------------------------
module csc_post (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  csc_pkg::csc_data_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [csc_pkg::OUT_W-1:0]    sine,
  output logic signed [csc_pkg::OUT_W-1:0]    cosine,
  output logic                                out_of_range
);

  logic signed [csc_pkg::XY_W-1:0] y_sat;
  logic signed [csc_pkg::XY_W-1:0] x_sat;
  logic signed [csc_pkg::OUT_W-1:0] sine_next;
  logic signed [csc_pkg::OUT_W-1:0] cosine_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    priority if (in_data.y > csc_pkg::SAT_MAX) begin
      y_sat = csc_pkg::SAT_MAX;
    end else if (in_data.y < csc_pkg::SAT_MIN) begin
      y_sat = csc_pkg::SAT_MIN;
    end else begin
      y_sat = in_data.y;
    end
    priority if (in_data.x > csc_pkg::SAT_MAX) begin
      x_sat = csc_pkg::SAT_MAX;
    end else if (in_data.x < csc_pkg::SAT_MIN) begin
      x_sat = csc_pkg::SAT_MIN;
    end else begin
      x_sat = in_data.x;
    end
    if (in_data.oor) begin
      sine_next   = '0;
      cosine_next = '0;
    end else begin
      sine_next   = y_sat[csc_pkg::OUT_W-1:0];
      cosine_next = x_sat[csc_pkg::OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sine         <= sine_next;
      cosine       <= cosine_next;
      out_of_range <= in_data.oor;
    end
  end

endmodule

// ===== rtl/cordic_sine_cosine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cordic_sine_cosine
// pipelined cordic sine and cosine of a q14 angle
// ----------------------------------------------------------------------------
// Accepts one angle per clock unless back-pressure on the master side has filled
// the pipeline, and returns its sine and cosine in q15 through one input
// register, one register per cordic iteration and one output register. Angles
// beyond +/- pi/2 give zero results with the range flag set. Back-pressure on
// the master side holds every stage in place; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module cordic_sine_cosine (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // angle[15:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // sine[15:0], cosine[31:16]
  output logic [0:0]  m_tuser    // out_of_range[0]
);

  localparam int N = csc_pkg::ITERATIONS;

  logic               valid [N+1];
  logic               ready [N+1];
  csc_pkg::csc_data_t data  [N+1];

  logic signed [csc_pkg::OUT_W-1:0] sine;
  logic signed [csc_pkg::OUT_W-1:0] cosine;
  logic                             out_of_range;

  csc_pre u_pre (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .angle     (s_tdata),
    .out_valid (valid[0]),
    .out_ready (ready[0]),
    .out_data  (data[0])
  );

  for (genvar i = 0; i < N; i++) begin : g_stage
    csc_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .shift     (csc_pkg::IDX_W'(i)),
      .atan      (csc_pkg::atan_q14(csc_pkg::IDX_W'(i))),
      .in_valid  (valid[i]),
      .in_ready  (ready[i]),
      .in_data   (data[i]),
      .out_valid (valid[i+1]),
      .out_ready (ready[i+1]),
      .out_data  (data[i+1])
    );
  end

  csc_post u_post (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (valid[N]),
    .in_ready     (ready[N]),
    .in_data      (data[N]),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .sine         (sine),
    .cosine       (cosine),
    .out_of_range (out_of_range)
  );

  assign m_tdata = {cosine, sine};
  assign m_tuser = out_of_range;

endmodule

// ===== rtl/csc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_checker
// port-level checks for cordic_sine_cosine
// ----------------------------------------------------------------------------
module csc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [15:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [0:0]  m_tuser
);

  // stalled output transfer holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled output changed");

  // out of range results are zero
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == 32'd0)
    else $error("out of range result not zero");

  // empty output register means the pipe can take an angle
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

endmodule

bind cordic_sine_cosine csc_checker u_csc_checker (.*);
